@@ rtl/core/cts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the Cartesian to spherical converter.
package cts_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int TURN_WIDTH   = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int FRAC_BITS    = 29;
  localparam int DATA_WIDTH   = COORD_WIDTH + 32;
  localparam int SUM_WIDTH    = 2 * COORD_WIDTH;
  localparam int GAIN_WIDTH   = 31;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_Q29 = 31'sd884097682;
  localparam logic [TURN_WIDTH-1:0] HALF_TURN       = 32'h8000_0000;
  localparam logic [TURN_WIDTH-1:0] THREE_QUARTERS  = 32'hC000_0000;
  localparam logic [TURN_WIDTH-1:0] ROUND_HALF      =
      TURN_WIDTH'(1) << (TURN_WIDTH - 1 - ANGLE_WIDTH);

  localparam logic [TURN_WIDTH-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
  } vec_item_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] radius;
    logic [ANGLE_WIDTH-1:0] azimuth;
    logic [ANGLE_WIDTH-1:0] polar_angle;
  } sph_item_t;

  function automatic logic [ANGLE_WIDTH-1:0] round_angle(input logic [TURN_WIDTH-1:0] a);
    logic [TURN_WIDTH-1:0] s;
    s = a + ROUND_HALF;
    return s[TURN_WIDTH-1 -: ANGLE_WIDTH];
  endfunction

endpackage

@@ rtl/core/cts_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined rounded integer square root, one result bit per stage.
module cts_isqrt import cts_pkg::*; #(
  parameter int SIDE_WIDTH = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [SUM_WIDTH-1:0]   in_sum,
  input  logic [SIDE_WIDTH-1:0]  in_side,
  output logic                   out_valid,
  output logic [COORD_WIDTH-1:0] out_root,
  output logic [SIDE_WIDTH-1:0]  out_side
);

  logic [SUM_WIDTH-1:0]  rem_q   [0:COORD_WIDTH-1];
  logic [SUM_WIDTH-1:0]  res_q   [0:COORD_WIDTH-1];
  logic [SIDE_WIDTH-1:0] side_q  [0:COORD_WIDTH-1];
  logic                  valid_q [0:COORD_WIDTH-1];

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_stage
    localparam logic [SUM_WIDTH-1:0] BIT = SUM_WIDTH'(1) << (SUM_WIDTH - 2 - 2 * i);
    logic [SUM_WIDTH-1:0]  rem_in;
    logic [SUM_WIDTH-1:0]  res_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic                  valid_in;
    logic [SUM_WIDTH-1:0]  trial;

    if (i == 0) begin : g_first
      assign rem_in   = in_sum;
      assign res_in   = '0;
      assign side_in  = in_side;
      assign valid_in = in_valid;
    end else begin : g_next
      assign rem_in   = rem_q[i-1];
      assign res_in   = res_q[i-1];
      assign side_in  = side_q[i-1];
      assign valid_in = valid_q[i-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i] <= side_in;
        if (rem_in >= trial) begin
          rem_q[i] <= rem_in - trial;
          res_q[i] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[i] <= rem_in;
          res_q[i] <= res_in >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_q[COORD_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_q[COORD_WIDTH-1];
      out_root <= COORD_WIDTH'(res_q[COORD_WIDTH-1]
                  + SUM_WIDTH'(rem_q[COORD_WIDTH-1] > res_q[COORD_WIDTH-1]));
    end
  end

endmodule

@@ rtl/core/cts_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring unit, one micro-rotation per stage.
module cts_cordic import cts_pkg::*; #(
  parameter int SIDE_WIDTH = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  input  logic [SIDE_WIDTH-1:0]        in_side,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic [TURN_WIDTH-1:0]        out_angle,
  output logic [SIDE_WIDTH-1:0]        out_side
);

  logic signed [DATA_WIDTH-1:0] x_q     [0:CORDIC_STEPS];
  logic signed [DATA_WIDTH-1:0] y_q     [0:CORDIC_STEPS];
  logic [TURN_WIDTH-1:0]        a_q     [0:CORDIC_STEPS];
  logic [SIDE_WIDTH-1:0]        side_q  [0:CORDIC_STEPS];
  logic                         valid_q [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid;
    end
  end

  // Vectors in the left half-plane are turned by half a turn first.
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      if (in_x[DATA_WIDTH-1]) begin
        x_q[0] <= -in_x;
        y_q[0] <= -in_y;
        a_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= in_x;
        y_q[0] <= in_y;
        a_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic y_pos;
    assign y_pos = !y_q[k][DATA_WIDTH-1] && (y_q[k] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
        if (y_pos) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          a_q[k+1] <= a_q[k] + ATAN_TURNS[k];
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          a_q[k+1] <= a_q[k] - ATAN_TURNS[k];
        end
      end
    end
  end

  assign out_valid = valid_q[CORDIC_STEPS];
  assign out_x     = x_q[CORDIC_STEPS];
  assign out_angle = a_q[CORDIC_STEPS];
  assign out_side  = side_q[CORDIC_STEPS];

endmodule

@@ rtl/core/cartesian_to_spherical_core.sv @@
`timescale 1ns / 1ps
// Top level of the Cartesian to spherical converter.
// The block takes one signed vector (x, y, z) per cycle and returns its radius,
// azimuth and polar angle, with angles in units of a full turn over 2^16. It is a
// fully pipelined datapath: two stages form the squares and their sum together with
// z times the CORDIC gain, 17 stages take the rounded square root, and two CORDIC
// vectoring units of 33 stages each give the azimuth and then the polar angle. A new
// item is taken every cycle; when the output is held back, the whole pipeline stalls
// and nothing is lost.
module cartesian_to_spherical_core import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      vec_valid,
  output logic      vec_ready,
  input  vec_item_t vec,
  output logic      sph_valid,
  input  logic      sph_ready,
  output sph_item_t sph
);

  localparam int SQ_SIDE  = 2 * COORD_WIDTH + DATA_WIDTH + 1;
  localparam int AZ_SIDE  = COORD_WIDTH + DATA_WIDTH + 2;
  localparam int POL_SIDE = COORD_WIDTH + ANGLE_WIDTH + 1;

  logic en;
  assign en        = !sph_valid || sph_ready;
  assign vec_ready = en;

  logic                          valid1;
  logic signed [COORD_WIDTH-1:0] x1, y1, z1;
  logic [SUM_WIDTH-1:0]          sqx1, sqy1, sqz1;
  logic [COORD_WIDTH-1:0]        ax, ay, az;

  assign ax = vec.coord_x[COORD_WIDTH-1] ? COORD_WIDTH'(-vec.coord_x) : vec.coord_x;
  assign ay = vec.coord_y[COORD_WIDTH-1] ? COORD_WIDTH'(-vec.coord_y) : vec.coord_y;
  assign az = vec.coord_z[COORD_WIDTH-1] ? COORD_WIDTH'(-vec.coord_z) : vec.coord_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= vec.coord_x;
      y1   <= vec.coord_y;
      z1   <= vec.coord_z;
      sqx1 <= ax * ax;
      sqy1 <= ay * ay;
      sqz1 <= az * az;
    end
  end

  logic                                   valid2;
  logic signed [COORD_WIDTH-1:0]          x2, y2;
  logic signed [DATA_WIDTH-1:0]           zg2;
  logic [SUM_WIDTH-1:0]                   sum2;
  logic signed [COORD_WIDTH+GAIN_WIDTH-1:0] zprod;

  assign zprod = z1 * GAIN_Q29;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (en) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= x1;
      y2   <= y1;
      zg2  <= DATA_WIDTH'(zprod);
      sum2 <= sqx1 + sqy1 + sqz1;
    end
  end

  logic                          sq_valid;
  logic [COORD_WIDTH-1:0]        sq_root;
  logic [SQ_SIDE-1:0]            sq_side;
  logic signed [COORD_WIDTH-1:0] sq_x, sq_y;
  logic signed [DATA_WIDTH-1:0]  sq_zg;
  logic                          sq_nz;

  cts_isqrt #(.SIDE_WIDTH(SQ_SIDE)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (valid2),
    .in_sum   (sum2),
    .in_side  ({x2, y2, zg2, sum2 != '0}),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign {sq_x, sq_y, sq_zg, sq_nz} = sq_side;

  logic signed [DATA_WIDTH-1:0] az_in_x, az_in_y;
  assign az_in_x = DATA_WIDTH'(sq_x) <<< FRAC_BITS;
  assign az_in_y = DATA_WIDTH'(sq_y) <<< FRAC_BITS;

  logic                         az_valid;
  logic signed [DATA_WIDTH-1:0] az_len;
  logic [TURN_WIDTH-1:0]        az_angle;
  logic [AZ_SIDE-1:0]           az_side;
  logic [COORD_WIDTH-1:0]       az_root;
  logic signed [DATA_WIDTH-1:0] az_zg;
  logic                         az_xy_nz, az_nz;

  cts_cordic #(.SIDE_WIDTH(AZ_SIDE)) u_azimuth (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .in_x     (az_in_x),
    .in_y     (az_in_y),
    .in_side  ({sq_root, sq_zg, (sq_x != '0) || (sq_y != '0), sq_nz}),
    .out_valid(az_valid),
    .out_x    (az_len),
    .out_angle(az_angle),
    .out_side (az_side)
  );

  assign {az_root, az_zg, az_xy_nz, az_nz} = az_side;

  logic [ANGLE_WIDTH-1:0] az_out;
  assign az_out = az_xy_nz ? round_angle(az_angle) : '0;

  logic                         pol_valid;
  logic signed [DATA_WIDTH-1:0] pol_len;
  logic [TURN_WIDTH-1:0]        pol_angle;
  logic [POL_SIDE-1:0]          pol_side;
  logic [COORD_WIDTH-1:0]       pol_root;
  logic [ANGLE_WIDTH-1:0]       pol_az;
  logic                         pol_nz;

  cts_cordic #(.SIDE_WIDTH(POL_SIDE)) u_polar (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (az_valid),
    .in_x     (az_zg),
    .in_y     (az_len),
    .in_side  ({az_root, az_out, az_nz}),
    .out_valid(pol_valid),
    .out_x    (pol_len),
    .out_angle(pol_angle),
    .out_side (pol_side)
  );

  assign {pol_root, pol_az, pol_nz} = pol_side;

  // A small overshoot past either pole is folded back onto it.
  logic [TURN_WIDTH-1:0]  pol_clamped;
  logic [ANGLE_WIDTH-1:0] pol_out;
  logic                   len_sign;

  assign len_sign = pol_len[DATA_WIDTH-1];

  always_comb begin
    if (pol_angle >= THREE_QUARTERS) begin
      pol_clamped = '0;
    end else if (pol_angle > HALF_TURN) begin
      pol_clamped = HALF_TURN;
    end else begin
      pol_clamped = pol_angle;
    end
    pol_out = (pol_nz || len_sign) && pol_nz ? round_angle(pol_clamped) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sph_valid <= 1'b0;
    end else if (en) begin
      sph_valid <= pol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sph.radius      <= pol_root;
      sph.azimuth     <= pol_az;
      sph.polar_angle <= pol_out;
    end
  end

`ifndef SYNTHESIS
  a_polar_range: assert property (@(posedge clk) disable iff (rst)
      sph_valid |-> (sph.polar_angle <= (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1))))
    else $error("polar angle beyond half a turn");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
      sph_valid && (sph.radius == '0) |-> (sph.azimuth == '0) && (sph.polar_angle == '0))
    else $error("zero radius item with nonzero angle");

  a_reset_empty: assert property (@(posedge clk)
      rst |=> !sph_valid)
    else $error("result valid straight after reset");
`endif

endmodule
